FILE: rtl/core/pbd_pkg.sv
// Shared types, constants and character classification for the PEM base64 decoder.
package pbd_pkg;

   localparam int unsigned BeginLen = 11;
   localparam int unsigned EndLen   = 9;

   localparam logic [7:0] ChDash  = 8'h2d;
   localparam logic [7:0] ChLf    = 8'h0a;
   localparam logic [7:0] ChCr    = 8'h0d;
   localparam logic [7:0] ChTab   = 8'h09;
   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChPad   = 8'h3d;
   localparam logic [7:0] ChPlus  = 8'h2b;
   localparam logic [7:0] ChSlash = 8'h2f;

   localparam logic [5:0] SextetPlus  = 6'h3e;
   localparam logic [5:0] SextetSlash = 6'h3f;

   typedef enum logic [1:0] {
      STATUS_RUN   = 2'd0,
      STATUS_OK    = 2'd1,
      STATUS_ERROR = 2'd2
   } status_type;

   // one classified text byte as it sits in the queue
   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_text;
      logic       is_dash;
      logic       is_lf;
      logic       is_space;
      logic       is_pad;
      logic       sextet_ok;
      logic [5:0] sextet;
   } entry_type;

   function automatic logic [7:0] begin_char(input logic [3:0] idx);
      logic [7:0] ch;
      unique case (idx)
         4'd0, 4'd1, 4'd2, 4'd3, 4'd4: ch = ChDash;
         4'd5:    ch = 8'h42;
         4'd6:    ch = 8'h45;
         4'd7:    ch = 8'h47;
         4'd8:    ch = 8'h49;
         4'd9:    ch = 8'h4e;
         default: ch = ChSpace;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] end_char(input logic [3:0] idx);
      logic [7:0] ch;
      unique case (idx)
         4'd0, 4'd1, 4'd2, 4'd3, 4'd4: ch = ChDash;
         4'd5:    ch = 8'h45;
         4'd6:    ch = 8'h4e;
         4'd7:    ch = 8'h44;
         default: ch = ChSpace;
      endcase
      return ch;
   endfunction

   function automatic entry_type classify(input logic [7:0] b, input logic last);
      entry_type e;
      logic [7:0] v;
      e.in_byte     = b;
      e.end_of_text = last;
      e.is_dash     = (b == ChDash);
      e.is_lf       = (b == ChLf);
      e.is_space    = (b == ChLf) || (b == ChCr) || (b == ChTab) || (b == ChSpace);
      e.is_pad      = (b == ChPad);
      e.sextet_ok   = 1'b1;
      v             = 8'h00;
      if (b >= 8'h41 && b <= 8'h5a) begin
         v = b - 8'd65;
      end else if (b >= 8'h61 && b <= 8'h7a) begin
         v = b - 8'd71;
      end else if (b >= 8'h30 && b <= 8'h39) begin
         v = b + 8'd4;
      end else if (b == ChPlus) begin
         v = {2'b00, SextetPlus};
      end else if (b == ChSlash) begin
         v = {2'b00, SextetSlash};
      end else begin
         e.sextet_ok = 1'b0;
      end
      e.sextet = v[5:0];
      return e;
   endfunction

endpackage

FILE: rtl/core/pbd_ifs.sv
// Valid/ready channel interfaces for text input and decoded output.
interface pbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_text;
   modport source (output valid, output in_byte, output end_of_text, input ready);
   modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface pbd_rsp_if;
   logic       valid;
   logic       ready;
   logic       has_byte;
   logic [7:0] out_byte;
   logic       finished;
   logic [1:0] status;
   modport source (output valid, output has_byte, output out_byte, output finished,
                   output status, input ready);
   modport sink (input valid, input has_byte, input out_byte, input finished,
                 input status, output ready);
endinterface

FILE: rtl/core/pbd_front.sv
// Front end: accepts text beats and classifies each character for the queue.
module pbd_front (
   pbd_req_if.sink            req_chan,
   output logic               push_valid,
   output pbd_pkg::entry_type push_entry,
   input  logic               push_ready
);
   import pbd_pkg::*;

   assign push_valid     = req_chan.valid;
   assign push_entry     = classify(req_chan.in_byte, req_chan.end_of_text);
   assign req_chan.ready = push_ready;

endmodule

FILE: rtl/core/pbd_queue.sv
// Small FIFO of classified characters between front and back.
module pbd_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  pbd_pkg::entry_type push_entry,
   output logic               push_ready,
   output logic               pop_valid,
   output pbd_pkg::entry_type pop_entry,
   input  logic               pop_ready
);
   import pbd_pkg::*;

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

   entry_type       slots_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            push, pop;

   assign push_ready = (count_ff != CntW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slots_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   overflow_check: assert property (@(posedge clock) disable iff (reset)
      count_ff == CntW'(DEPTH) |-> !push)
      else $error("queue written while full");

   count_track: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a push");

   underflow_check: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> !pop)
      else $error("queue read while empty");

endmodule

FILE: rtl/core/pbd_back.sv
// Back end: marker tracking, base64 decoding and the registered result beat.
module pbd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   input  pbd_pkg::entry_type pop_entry,
   output logic               pop_ready,
   pbd_rsp_if.source          rsp_chan
);
   import pbd_pkg::*;

   typedef enum logic [1:0] {
      PH_SEEK   = 2'd0,
      PH_HEADER = 2'd1,
      PH_DECODE = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [3:0] match_ff, match_in;
   logic       line_start_ff, line_start_in;
   logic [1:0] sextet_idx_ff, sextet_idx_in;
   logic [7:0] partial_ff, partial_in;
   logic       error_ff, error_in;

   logic       rsp_valid_ff;
   logic       has_byte_ff, has_byte_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       finished_ff, finished_in;
   status_type status_ff, status_in;

   logic       pop;
   entry_type  e;

   assign e         = pop_entry;
   assign pop_ready = !rsp_valid_ff || rsp_chan.ready;
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      phase_in      = phase_ff;
      match_in      = match_ff;
      line_start_in = line_start_ff;
      sextet_idx_in = sextet_idx_ff;
      partial_in    = partial_ff;
      error_in      = error_ff;
      has_byte_in   = 1'b0;
      out_byte_in   = 8'h00;

      unique case (phase_ff)
         PH_SEEK: begin
            if (match_ff != 4'd0 && match_ff < 4'(BeginLen)) begin
               if (e.in_byte == begin_char(match_ff)) begin
                  if (match_ff == 4'(BeginLen - 1)) begin
                     phase_in = PH_HEADER;
                     match_in = 4'd0;
                  end else begin
                     match_in = match_ff + 4'd1;
                  end
               end else begin
                  match_in      = 4'd0;
                  line_start_in = e.is_lf;
               end
            end else if (line_start_ff && e.is_dash) begin
               match_in      = 4'd1;
               line_start_in = 1'b0;
            end else begin
               match_in      = 4'd0;
               line_start_in = e.is_lf;
            end
         end
         PH_HEADER: begin
            if (e.is_lf) begin
               phase_in      = PH_DECODE;
               line_start_in = 1'b1;
            end
         end
         PH_DECODE: begin
            if (match_ff != 4'd0) begin
               if (match_ff < 4'(EndLen) && e.in_byte == end_char(match_ff)) begin
                  match_in = match_ff + 4'd1;
               end else if (match_ff == 4'(EndLen)) begin
                  phase_in = PH_DONE;
                  match_in = 4'd0;
               end else begin
                  error_in = 1'b1;
                  phase_in = PH_DONE;
                  match_in = 4'd0;
               end
            end else if (line_start_ff && e.is_dash) begin
               match_in      = 4'd1;
               line_start_in = 1'b0;
            end else begin
               line_start_in = e.is_lf;
               if (e.is_space) begin
                  // skip whitespace
               end else if (e.is_pad) begin
                  if (sextet_idx_ff == 2'd1) begin
                     has_byte_in = 1'b1;
                     out_byte_in = partial_ff;
                  end
                  phase_in = PH_DONE;
               end else if (!e.sextet_ok) begin
                  error_in = 1'b1;
                  phase_in = PH_DONE;
                  match_in = 4'd0;
               end else begin
                  unique case (sextet_idx_ff)
                     2'd0: begin
                        partial_in = {e.sextet, 2'b00};
                     end
                     2'd1: begin
                        has_byte_in = 1'b1;
                        out_byte_in = partial_ff | {6'b0, e.sextet[5:4]};
                        partial_in  = {e.sextet[3:0], 4'b0000};
                     end
                     2'd2: begin
                        has_byte_in = 1'b1;
                        out_byte_in = partial_ff | {4'b0, e.sextet[5:2]};
                        partial_in  = {e.sextet[1:0], 6'b000000};
                     end
                     default: begin
                        has_byte_in = 1'b1;
                        out_byte_in = partial_ff | {2'b0, e.sextet};
                     end
                  endcase
                  sextet_idx_in = sextet_idx_ff + 2'd1;
               end
            end
         end
         default: begin
            // hold until end of text
         end
      endcase

      // text ends inside or right after an end marker
      if (e.end_of_text && phase_in == PH_DECODE && match_in != 4'd0) begin
         error_in = 1'b1;
         phase_in = PH_DONE;
         match_in = 4'd0;
      end

      finished_in = (phase_in == PH_DONE) || e.end_of_text;
      if (error_in) begin
         status_in = STATUS_ERROR;
      end else if (finished_in) begin
         status_in = STATUS_OK;
      end else begin
         status_in = STATUS_RUN;
      end

      if (e.end_of_text) begin
         phase_in      = PH_SEEK;
         match_in      = 4'd0;
         line_start_in = 1'b1;
         sextet_idx_in = 2'd0;
         partial_in    = 8'h00;
         error_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SEEK;
         match_ff      <= 4'd0;
         line_start_ff <= 1'b1;
         sextet_idx_ff <= 2'd0;
         partial_ff    <= 8'h00;
         error_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff      <= phase_in;
            match_ff      <= match_in;
            line_start_ff <= line_start_in;
            sextet_idx_ff <= sextet_idx_in;
            partial_ff    <= partial_in;
            error_ff      <= error_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         has_byte_ff <= has_byte_in;
         out_byte_ff <= out_byte_in;
         finished_ff <= finished_in;
         status_ff   <= status_in;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.has_byte = has_byte_ff;
   assign rsp_chan.out_byte = out_byte_ff;
   assign rsp_chan.finished = finished_ff;
   assign rsp_chan.status   = status_ff;

   byte_not_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && has_byte_ff |-> status_ff != STATUS_ERROR)
      else $error("decoded byte carried with error status");

   running_until_finished: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !finished_ff |-> status_ff == STATUS_RUN)
      else $error("status set before stream finished");

   last_restores_reset: assert property (@(posedge clock) disable iff (reset)
      pop && e.end_of_text |=> phase_ff == PH_SEEK && match_ff == 4'd0 && !error_ff)
      else $error("end of text did not restart the decoder");

   error_ends_decode: assert property (@(posedge clock) disable iff (reset)
      error_ff |-> phase_ff == PH_DONE)
      else $error("error flag set outside done phase");

endmodule

FILE: rtl/core/pem_base64_decoder.sv
// Top level of the PEM base64 decoder: classify front, queue, decode back.
//
//   channel    dir   beat contents                          accepted when
//   req_chan   in    in_byte, end_of_text                   valid && ready
//   rsp_chan   out   has_byte, out_byte, finished, status   valid && ready
//
// One result beat per text beat, one beat per cycle sustained while rsp is ready.
// A req beat is written into the queue, then popped into the result register that drives rsp.
// The back end updates its state and result register together when it pops a beat.
// Reset is synchronous and returns the decoder to seeking the begin marker.
// A stall on rsp fills the queue; req ready drops only when the queue is full.
module pem_base64_decoder #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   pbd_req_if.sink   req_chan,
   pbd_rsp_if.source rsp_chan
);
   import pbd_pkg::*;

   logic      push_valid, push_ready;
   entry_type push_entry;
   logic      pop_valid, pop_ready;
   entry_type pop_entry;

   pbd_front u_front (
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   pbd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   pbd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop_ready (pop_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule
